// ===== sv/red_pkg.sv =====
// shared types, constants and codes for the red ecn marker with pfc
package red_pkg;

    localparam int QUEUE_BYTES_WIDTH = 24;
    localparam int FRAC_BITS         = 16;
    localparam int THR_WIDTH         = 24;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 24;
    localparam int SINCE_WIDTH       = 17;
    localparam int FIFO_DEPTH        = 2;

    localparam logic signed [SINCE_WIDTH-1:0] SINCE_RESET = -17'sd1;
    localparam logic signed [SINCE_WIDTH-1:0] SINCE_MAX   = 17'sd65535;

    localparam logic [15:0]          AVG_WEIGHT_RESET    = 16'd13107;
    localparam logic [15:0]          MAX_MARK_PROB_RESET = 16'd655;
    localparam logic [THR_WIDTH-1:0] MIN_THRESHOLD_RESET = 24'd5000;
    localparam logic [THR_WIDTH-1:0] MAX_THRESHOLD_RESET = 24'd200000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PFC_ENABLE         = 3'd0,
        REG_CONGESTION_CONTROL = 3'd1,
        REG_PAUSE_THRESHOLD    = 3'd2,
        REG_UNPAUSE_THRESHOLD  = 3'd3,
        REG_AVG_WEIGHT         = 3'd4,
        REG_MAX_MARK_PROB      = 3'd5,
        REG_MIN_THRESHOLD      = 3'd6,
        REG_MAX_THRESHOLD      = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PAUSE   = 2'd1,
        ACT_UNPAUSE = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW_A,
        S_POW_B,
        S_POW_C,
        S_AVG_HI,
        S_AVG_LO,
        S_AVG_QW,
        S_AVG_SUM,
        S_CMP,
        S_DIV_R,
        S_MUL_PB,
        S_MUL_D,
        S_LOAD_PA,
        S_DIV_PA,
        S_FIN_PA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 pfc_enable;
        logic                 congestion_control;
        logic [THR_WIDTH-1:0] pause_threshold;
        logic [THR_WIDTH-1:0] unpause_threshold;
        logic [15:0]          avg_weight;
        logic [15:0]          max_mark_prob;
        logic [THR_WIDTH-1:0] min_threshold;
        logic [THR_WIDTH-1:0] max_threshold;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic pause_sent;
    } t_stat;

endpackage

// ===== sv/red_front.sv =====
// front end: accepts queue events, classifies them and buffers them in a short queue
module red_front #(
    parameter int QW = red_pkg::QUEUE_BYTES_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_req_type,
    input  logic [QW-1:0] i_queue_bytes,
    input  logic [31:0]   i_now_ticks,
    input  logic          i_ecn_capable,
    input  logic          i_already_ce,
    input  logic [15:0]   i_rand_value,
    input  logic          i_cc,
    output logic          o_item_valid,
    input  logic          i_item_pop,
    output logic          o_deq,
    output logic          o_elig,
    output logic [QW-1:0] o_q,
    output logic [31:0]   o_now,
    output logic [15:0]   o_rnd
);

    localparam int IW = 2 + QW + 32 + 16;
    localparam int PTRW = $clog2(red_pkg::FIFO_DEPTH);
    localparam int CNTW = $clog2(red_pkg::FIFO_DEPTH + 1);

    logic [IW-1:0]   r_mem [red_pkg::FIFO_DEPTH];
    logic [PTRW-1:0] r_wp, n_wp;
    logic [PTRW-1:0] r_rp, n_rp;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            elig;
    logic [IW-1:0]   rd;

    assign o_in_ready   = (r_cnt != CNTW'(red_pkg::FIFO_DEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign o_item_valid = (r_cnt != '0);
    assign elig         = i_cc && i_ecn_capable && !i_already_ce;

    always_comb begin
        n_wp  = push ? PTRW'(r_wp + 1'b1) : r_wp;
        n_rp  = i_item_pop ? PTRW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (push && !i_item_pop) begin
            n_cnt = CNTW'(r_cnt + 1'b1);
        end else if (!push && i_item_pop) begin
            n_cnt = CNTW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wp] <= {i_req_type, elig, i_queue_bytes, i_now_ticks, i_rand_value};
        end
    end

    assign rd     = r_mem[r_rp];
    assign o_deq  = rd[IW-1];
    assign o_elig = rd[IW-2];
    assign o_q    = rd[IW-3 -: QW];
    assign o_now  = rd[47:16];
    assign o_rnd  = rd[15:0];

endmodule

// ===== sv/red_back.sv =====
// back end: pause hysteresis, red average update and marking decision sequencer
module red_back #(
    parameter int QW = red_pkg::QUEUE_BYTES_WIDTH,
    parameter int FB = red_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  red_pkg::t_cfg i_cfg,
    input  logic          i_item_valid,
    output logic          o_item_pop,
    input  logic          i_deq,
    input  logic          i_elig,
    input  logic [QW-1:0] i_q,
    input  logic [31:0]   i_now,
    input  logic [15:0]   i_rnd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_mark_ce,
    output logic [1:0]    o_pause_action,
    output red_pkg::t_stat o_stat
);

    localparam int TW   = red_pkg::THR_WIDTH;
    localparam int SW   = red_pkg::SINCE_WIDTH;
    localparam int AW   = QW + FB;
    localparam int BW   = FB + 1;
    localparam int MAW0 = (QW > BW) ? QW : BW;
    localparam int MAW  = (MAW0 > SW) ? MAW0 : SW;
    localparam int PW   = MAW + BW;
    localparam int DVW  = (TW > BW) ? TW : BW;
    localparam int XW   = (AW > TW + FB) ? AW : TW + FB;
    localparam int CNTW = $clog2(FB + 1);
    localparam int SHL  = (FB >= 16) ? FB - 16 : 0;
    localparam int SHR  = (FB >= 16) ? 0 : 16 - FB;
    localparam logic [BW-1:0] ONE = {1'b1, {FB{1'b0}}};

    function automatic logic [FB-1:0] q16f(input logic [15:0] v);
        logic [FB+15:0] t;
        t = (FB + 16)'(v);
        t = (t << SHL) >> SHR;
        return t[FB-1:0];
    endfunction

    red_pkg::t_state r_state, n_state;

    logic [AW-1:0]          r_avg;
    logic signed [SW-1:0]   r_since;
    logic [31:0]            r_empty;
    logic                   r_ps;
    logic                   r_out_valid;
    logic                   r_out_mark;
    logic [1:0]             r_out_act;

    logic [QW-1:0]          r_q;
    logic [FB-1:0]          r_rnd;
    logic                   r_mark;
    red_pkg::t_action       r_act;
    logic [BW-1:0]          r_mb;
    logic [BW-1:0]          r_pacc;
    logic [BW-1:0]          r_base;
    logic [31:0]            r_exp;
    logic [AW-1:0]          r_sum;
    logic [PW-1:0]          r_prod;
    logic [BW-1:0]          r_pb;
    logic [DVW-1:0]         r_rem;
    logic [FB-1:0]          r_dnum;
    logic [DVW-1:0]         r_div;
    logic [CNTW-1:0]        r_cnt;

    logic [MAW-1:0]         mul_a;
    logic [BW-1:0]          mul_b;
    logic                   pop;
    logic                   out_free;
    logic [FB-1:0]          w_f;
    logic [BW-1:0]          omw;
    logic [FB-1:0]          maxp_f;
    logic [XW-1:0]          minf, maxf, avg_x, diff;
    logic                   in_band, above;
    logic [BW-1:0]          prod_pb;
    logic                   d_pos;
    logic [BW-1:0]          d_val;
    logic                   sat_mark;
    logic [DVW:0]           dv_t;
    logic                   dv_ge;
    logic [DVW-1:0]         dv_rem;

    assign out_free = !r_out_valid || i_out_ready;
    assign w_f      = q16f(i_cfg.avg_weight);
    assign omw      = ONE - BW'(w_f);
    assign maxp_f   = q16f(i_cfg.max_mark_prob);
    assign minf     = XW'(i_cfg.min_threshold) << FB;
    assign maxf     = XW'(i_cfg.max_threshold) << FB;
    assign avg_x    = XW'(r_avg);
    assign diff     = avg_x - minf;
    assign in_band  = (minf <= avg_x) && (avg_x < maxf);
    assign above    = (maxf <= avg_x) || (32'(i_cfg.max_threshold) <= 32'(r_q));
    assign prod_pb  = BW'(r_prod >> FB);
    assign d_pos    = r_prod < PW'(ONE);
    assign d_val    = BW'(PW'(ONE) - r_prod);
    assign sat_mark = !d_pos || (r_pb >= d_val);
    assign dv_t     = {r_rem, r_dnum[FB-1]};
    assign dv_ge    = dv_t >= (DVW + 1)'(r_div);
    assign dv_rem   = dv_ge ? DVW'(dv_t - (DVW + 1)'(r_div)) : DVW'(dv_t);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            red_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    if (!i_deq && i_elig) begin
                        n_state = (i_q == '0) ? red_pkg::S_POW_A : red_pkg::S_AVG_HI;
                    end else begin
                        n_state = red_pkg::S_DONE;
                    end
                end
            end
            red_pkg::S_POW_A:   n_state = (r_exp == '0) ? red_pkg::S_AVG_HI : red_pkg::S_POW_B;
            red_pkg::S_POW_B:   n_state = red_pkg::S_POW_C;
            red_pkg::S_POW_C:   n_state = red_pkg::S_POW_A;
            red_pkg::S_AVG_HI:  n_state = red_pkg::S_AVG_LO;
            red_pkg::S_AVG_LO:  n_state = red_pkg::S_AVG_QW;
            red_pkg::S_AVG_QW:  n_state = red_pkg::S_AVG_SUM;
            red_pkg::S_AVG_SUM: n_state = red_pkg::S_CMP;
            red_pkg::S_CMP:     n_state = in_band ? red_pkg::S_DIV_R : red_pkg::S_DONE;
            red_pkg::S_DIV_R:   n_state = (r_cnt == CNTW'(1)) ? red_pkg::S_MUL_PB : red_pkg::S_DIV_R;
            red_pkg::S_MUL_PB:  n_state = red_pkg::S_MUL_D;
            red_pkg::S_MUL_D:   n_state = red_pkg::S_LOAD_PA;
            red_pkg::S_LOAD_PA: n_state = sat_mark ? red_pkg::S_DONE : red_pkg::S_DIV_PA;
            red_pkg::S_DIV_PA:  n_state = (r_cnt == CNTW'(1)) ? red_pkg::S_FIN_PA : red_pkg::S_DIV_PA;
            red_pkg::S_FIN_PA:  n_state = red_pkg::S_DONE;
            red_pkg::S_DONE:    n_state = out_free ? red_pkg::S_IDLE : red_pkg::S_DONE;
            default:            n_state = red_pkg::S_IDLE;
        endcase
    end

    // shared multiplier operands and handshake outputs
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        pop   = 1'b0;
        unique case (r_state)
            red_pkg::S_IDLE: pop = i_item_valid;
            red_pkg::S_POW_A: begin
                mul_a = MAW'(r_pacc);
                mul_b = r_base;
            end
            red_pkg::S_POW_B: begin
                mul_a = MAW'(r_base);
                mul_b = r_base;
            end
            red_pkg::S_AVG_HI: begin
                mul_a = MAW'(r_avg[AW-1:FB]);
                mul_b = r_mb;
            end
            red_pkg::S_AVG_LO: begin
                mul_a = MAW'(r_avg[FB-1:0]);
                mul_b = r_mb;
            end
            red_pkg::S_AVG_QW: begin
                mul_a = MAW'(r_q);
                mul_b = BW'(w_f);
            end
            red_pkg::S_MUL_PB: begin
                mul_a = MAW'(r_dnum);
                mul_b = BW'(maxp_f);
            end
            red_pkg::S_MUL_D: begin
                mul_a = MAW'($unsigned(r_since));
                mul_b = prod_pb;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign o_item_pop     = pop;
    assign o_out_valid    = r_out_valid;
    assign o_mark_ce      = r_out_mark;
    assign o_pause_action = r_out_act;
    assign o_stat.done       = (r_state == red_pkg::S_DONE);
    assign o_stat.pause_sent = r_ps;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (!i_rst_n) begin
            r_state     <= red_pkg::S_IDLE;
            r_avg       <= '0;
            r_since     <= red_pkg::SINCE_RESET;
            r_empty     <= '0;
            r_ps        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == red_pkg::S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                red_pkg::S_IDLE: begin
                    if (i_item_valid) begin
                        r_q    <= i_q;
                        r_rnd  <= q16f(i_rnd);
                        r_mark <= 1'b0;
                        r_act  <= red_pkg::ACT_NONE;
                        r_mb   <= omw;
                        r_pacc <= ONE;
                        r_base <= omw;
                        r_exp  <= i_now - r_empty;
                        if (!i_deq) begin
                            if (i_cfg.pfc_enable && !r_ps &&
                                (32'(i_cfg.pause_threshold) <= 32'(i_q))) begin
                                r_ps  <= 1'b1;
                                r_act <= red_pkg::ACT_PAUSE;
                            end
                        end else begin
                            if (i_cfg.congestion_control && (i_q == '0)) begin
                                r_empty <= i_now;
                            end
                            if (i_cfg.pfc_enable && r_ps &&
                                (32'(i_q) <= 32'(i_cfg.unpause_threshold))) begin
                                r_ps  <= 1'b0;
                                r_act <= red_pkg::ACT_UNPAUSE;
                            end
                        end
                    end
                end
                red_pkg::S_POW_A: begin
                    if (r_exp == '0) begin
                        r_mb <= r_pacc;
                    end
                end
                red_pkg::S_POW_B: begin
                    if (r_exp[0]) begin
                        r_pacc <= BW'(r_prod >> FB);
                    end
                end
                red_pkg::S_POW_C: begin
                    r_base <= BW'(r_prod >> FB);
                    r_exp  <= r_exp >> 1;
                end
                red_pkg::S_AVG_LO:  r_sum <= AW'(r_prod);
                red_pkg::S_AVG_QW:  r_sum <= r_sum + AW'(r_prod >> FB);
                red_pkg::S_AVG_SUM: r_avg <= r_sum + AW'(r_prod);
                red_pkg::S_CMP: begin
                    if (in_band) begin
                        if (r_since < red_pkg::SINCE_MAX) begin
                            r_since <= r_since + SW'(1);
                        end
                        r_rem  <= DVW'(diff >> FB);
                        r_dnum <= diff[FB-1:0];
                        r_div  <= DVW'(i_cfg.max_threshold - i_cfg.min_threshold);
                        r_cnt  <= CNTW'(FB);
                    end else if (above) begin
                        r_mark  <= 1'b1;
                        r_since <= '0;
                    end else begin
                        r_since <= red_pkg::SINCE_RESET;
                    end
                end
                red_pkg::S_DIV_R, red_pkg::S_DIV_PA: begin
                    r_rem  <= dv_rem;
                    r_dnum <= {r_dnum[FB-2:0], dv_ge};
                    r_cnt  <= CNTW'(r_cnt - 1'b1);
                end
                red_pkg::S_MUL_D: r_pb <= prod_pb;
                red_pkg::S_LOAD_PA: begin
                    if (sat_mark) begin
                        r_mark  <= 1'b1;
                        r_since <= '0;
                    end else begin
                        r_rem  <= DVW'(r_pb);
                        r_dnum <= '0;
                        r_div  <= DVW'(d_val);
                        r_cnt  <= CNTW'(FB);
                    end
                end
                red_pkg::S_FIN_PA: begin
                    if (r_rnd < r_dnum) begin
                        r_mark  <= 1'b1;
                        r_since <= '0;
                    end
                end
                red_pkg::S_DONE: begin
                    if (out_free) begin
                        r_out_mark  <= r_mark;
                        r_out_act   <= r_act;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/red_ecn_marker_with_pfc.sv =====
// top level: red ecn marker with pfc pause, configuration registers and front/back split
//
//  channel | signals                              | transfer when
//  --------+--------------------------------------+-----------------------------
//  in      | i_in_valid o_in_ready + event fields | i_in_valid && o_in_ready
//  out     | o_out_valid i_out_ready + result     | o_out_valid && i_out_ready
//  cfg     | i_cfg_wr_en i_cfg_index i_cfg_wdata  | i_cfg_wr_en
//
//  dequeues and ineligible enqueues pass straight from idle to done in the back end sequencer
//  an eligible enqueue into a non-empty queue runs the average update and, when the average
//  lies in the band, the bit-serial dividers and the shared multiplier
//  an enqueue into an empty queue first runs a square-and-multiply step per significant bit of the idle time
//  a two-entry queue lets the front accept events while the back end works or stalls
//  reset is synchronous; results wait in the output register while the back stalls
module red_ecn_marker_with_pfc #(
    parameter int QUEUE_BYTES_WIDTH = red_pkg::QUEUE_BYTES_WIDTH,
    parameter int FRAC_BITS         = red_pkg::FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [red_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [red_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic [QUEUE_BYTES_WIDTH-1:0]         i_queue_bytes,
    input  logic [31:0]                          i_now_ticks,
    input  logic                                 i_ecn_capable,
    input  logic                                 i_already_ce,
    input  logic [15:0]                          i_rand_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_mark_ce,
    output logic [1:0]                           o_pause_action
);

    red_pkg::t_cfg  r_cfg;
    red_pkg::t_stat stat;

    logic                         item_valid;
    logic                         item_pop;
    logic                         item_deq;
    logic                         item_elig;
    logic [QUEUE_BYTES_WIDTH-1:0] item_q;
    logic [31:0]                  item_now;
    logic [15:0]                  item_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pfc_enable         <= 1'b0;
            r_cfg.congestion_control <= 1'b0;
            r_cfg.pause_threshold    <= '0;
            r_cfg.unpause_threshold  <= '0;
            r_cfg.avg_weight         <= red_pkg::AVG_WEIGHT_RESET;
            r_cfg.max_mark_prob      <= red_pkg::MAX_MARK_PROB_RESET;
            r_cfg.min_threshold      <= red_pkg::MIN_THRESHOLD_RESET;
            r_cfg.max_threshold      <= red_pkg::MAX_THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (red_pkg::t_reg_index'(i_cfg_index))
                red_pkg::REG_PFC_ENABLE:         r_cfg.pfc_enable         <= i_cfg_wdata[0];
                red_pkg::REG_CONGESTION_CONTROL: r_cfg.congestion_control <= i_cfg_wdata[0];
                red_pkg::REG_PAUSE_THRESHOLD:    r_cfg.pause_threshold    <= i_cfg_wdata;
                red_pkg::REG_UNPAUSE_THRESHOLD:  r_cfg.unpause_threshold  <= i_cfg_wdata;
                red_pkg::REG_AVG_WEIGHT:         r_cfg.avg_weight         <= i_cfg_wdata[15:0];
                red_pkg::REG_MAX_MARK_PROB:      r_cfg.max_mark_prob      <= i_cfg_wdata[15:0];
                red_pkg::REG_MIN_THRESHOLD:      r_cfg.min_threshold      <= i_cfg_wdata;
                red_pkg::REG_MAX_THRESHOLD:      r_cfg.max_threshold      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    red_front #(
        .QW (QUEUE_BYTES_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_queue_bytes (i_queue_bytes),
        .i_now_ticks   (i_now_ticks),
        .i_ecn_capable (i_ecn_capable),
        .i_already_ce  (i_already_ce),
        .i_rand_value  (i_rand_value),
        .i_cc          (r_cfg.congestion_control),
        .o_item_valid  (item_valid),
        .i_item_pop    (item_pop),
        .o_deq         (item_deq),
        .o_elig        (item_elig),
        .o_q           (item_q),
        .o_now         (item_now),
        .o_rnd         (item_rnd)
    );

    red_back #(
        .QW (QUEUE_BYTES_WIDTH),
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (item_valid),
        .o_item_pop     (item_pop),
        .i_deq          (item_deq),
        .i_elig         (item_elig),
        .i_q            (item_q),
        .i_now          (item_now),
        .i_rnd          (item_rnd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mark_ce      (o_mark_ce),
        .o_pause_action (o_pause_action),
        .o_stat         (stat)
    );

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stat.done))
        else $error("result appeared without the sequencer finishing");

    a_action_needs_pfc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pause_action != red_pkg::ACT_NONE)) |-> r_cfg.pfc_enable)
        else $error("pause action with pfc disabled");

    a_mark_needs_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mark_ce) |-> r_cfg.congestion_control)
        else $error("ce mark with congestion control disabled");

    a_pause_state_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.pause_sent != $past(stat.pause_sent)) |-> $past(r_cfg.pfc_enable))
        else $error("pause state changed with pfc disabled");

endmodule
